// ===== design/lpps_pkg.sv =====
package lpps_pkg;

	// field and register widths
	localparam int unsigned HoldW     = 16;
	localparam int unsigned RelW      = 10;
	localparam int unsigned DtW       = 8;
	localparam int unsigned ModeW     = 3;
	localparam int unsigned CfgIdxW   = 2;
	localparam int unsigned CfgDataW  = 16;

	// register reset values
	localparam logic [HoldW-1:0] HoldLimitRst  = 16'd3000;
	localparam logic [RelW-1:0]  RelStableRst  = 10'd30;

	// register indexes
	localparam logic [CfgIdxW-1:0] CfgIdxHold = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgIdxRel  = 2'd1;

	typedef enum logic [ModeW-1:0] {
		MODE_IDLE     = 3'd0,
		MODE_RUNNING  = 3'd1,
		MODE_SHUTTING = 3'd2,
		MODE_SLEEP    = 3'd3,
		MODE_OFF      = 3'd4
	} mode_t;

	typedef struct packed {
		mode_t            mode;
		logic             was_pressed;
		logic             hold_active;
		logic [HoldW-1:0] hold_elapsed;
		logic             rel_started;
		logic [RelW-1:0]  rel_elapsed;
	} seq_state_t;

	typedef struct packed {
		logic           button_pressed;
		logic           link_ready;
		logic           fade_done;
		logic [DtW-1:0] elapsed_ms;
	} tick_t;

	typedef struct packed {
		mode_t mode;
		logic  poll_enable;
		logic  start_fade;
		logic  prepare_off;
		logic  power_off;
	} result_t;

	typedef struct packed {
		logic [HoldW-1:0] hold_limit_ms;
		logic [RelW-1:0]  release_stable_ms;
	} cfg_t;

endpackage

// ===== design/lpps_cfg_regs.sv =====
module lpps_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lpps_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [lpps_pkg::CfgDataW-1:0]  cfg_data,
	output lpps_pkg::cfg_t                 cfg
);

	logic [lpps_pkg::HoldW-1:0] hold_limit_q;
	logic [lpps_pkg::RelW-1:0]  rel_stable_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_limit_q <= lpps_pkg::HoldLimitRst;
			rel_stable_q <= lpps_pkg::RelStableRst;
		end else if (cfg_we) begin
			case (cfg_index)
				lpps_pkg::CfgIdxHold: hold_limit_q <= cfg_data[lpps_pkg::HoldW-1:0];
				lpps_pkg::CfgIdxRel:  rel_stable_q <= cfg_data[lpps_pkg::RelW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.hold_limit_ms     = hold_limit_q;
	assign cfg.release_stable_ms = rel_stable_q;

endmodule

// ===== design/lpps_step.sv =====
module lpps_step (
	input  lpps_pkg::cfg_t       cfg,
	input  lpps_pkg::seq_state_t cur,
	input  lpps_pkg::tick_t      tick,
	output lpps_pkg::seq_state_t nxt,
	output lpps_pkg::result_t    res
);

	logic                       rising;
	logic                       hold_act_upd;
	logic [lpps_pkg::HoldW:0]   hold_sum;
	logic [lpps_pkg::HoldW-1:0] hold_upd;
	logic                       fire;
	logic [lpps_pkg::RelW:0]    rel_sum;
	logic [lpps_pkg::RelW-1:0]  rel_upd;

	// hold timer: restart on rising edge, accumulate while held, saturate
	always_comb begin
		rising   = tick.button_pressed && !cur.was_pressed;
		hold_sum = {1'b0, cur.hold_elapsed} + {{(lpps_pkg::HoldW+1-lpps_pkg::DtW){1'b0}},
			tick.elapsed_ms};
		if (rising) begin
			hold_act_upd = 1'b1;
			hold_upd     = '0;
		end else if (tick.button_pressed && cur.hold_active) begin
			hold_act_upd = 1'b1;
			hold_upd     = hold_sum[lpps_pkg::HoldW] ? '1 : hold_sum[lpps_pkg::HoldW-1:0];
		end else begin
			hold_act_upd = cur.hold_active;
			hold_upd     = cur.hold_elapsed;
		end
		fire = tick.button_pressed && hold_act_upd && (hold_upd >= cfg.hold_limit_ms);
	end

	// release timer sum, saturating
	always_comb begin
		rel_sum = {1'b0, cur.rel_elapsed} + {{(lpps_pkg::RelW+1-lpps_pkg::DtW){1'b0}},
			tick.elapsed_ms};
		rel_upd = rel_sum[lpps_pkg::RelW] ? '1 : rel_sum[lpps_pkg::RelW-1:0];
	end

	// mode sequencing
	always_comb begin
		nxt = cur;
		res = '{mode: lpps_pkg::MODE_OFF, poll_enable: 1'b0, start_fade: 1'b0,
			prepare_off: 1'b0, power_off: 1'b0};
		case (cur.mode)
			lpps_pkg::MODE_IDLE, lpps_pkg::MODE_RUNNING: begin
				nxt.was_pressed  = tick.button_pressed;
				nxt.hold_active  = tick.button_pressed && hold_act_upd;
				nxt.hold_elapsed = tick.button_pressed ? hold_upd : '0;
				if (fire) begin
					nxt.mode       = lpps_pkg::MODE_SHUTTING;
					res.start_fade = 1'b1;
				end else if (cur.mode == lpps_pkg::MODE_IDLE) begin
					if (tick.link_ready) begin
						nxt.mode = lpps_pkg::MODE_RUNNING;
					end
				end else begin
					res.poll_enable = 1'b1;
					if (!tick.link_ready) begin
						nxt.mode = lpps_pkg::MODE_IDLE;
					end
				end
			end
			lpps_pkg::MODE_SHUTTING: begin
				if (tick.fade_done) begin
					nxt.mode        = lpps_pkg::MODE_SLEEP;
					nxt.rel_started = 1'b0;
					nxt.rel_elapsed = '0;
					res.prepare_off = 1'b1;
				end
			end
			lpps_pkg::MODE_SLEEP: begin
				if (tick.button_pressed) begin
					nxt.rel_started = 1'b0;
					nxt.rel_elapsed = '0;
				end else if (!cur.rel_started) begin
					nxt.rel_started = 1'b1;
					nxt.rel_elapsed = '0;
				end else begin
					nxt.rel_elapsed = rel_upd;
					if (rel_upd >= cfg.release_stable_ms) begin
						nxt.mode      = lpps_pkg::MODE_OFF;
						res.power_off = 1'b1;
					end
				end
			end
			default: begin
				// off is terminal; stray codes fold into off
				nxt.mode = lpps_pkg::MODE_OFF;
			end
		endcase
		res.mode = nxt.mode;
	end

endmodule

// ===== design/long_press_power_sequencer_unit.sv =====
// A transferred tick is captured in the input register, and its result then in the result register.
// Throughput: one tick per cycle while out_stall lets the result register drain; the mode and timer
// registers update from the input register, so back-to-back ticks need no bubbles.
// Reset (arst_n low, asynchronous): mode idle, timers and edge flags cleared,
// hold_limit_ms = 3000, release_stable_ms = 30, both pipeline stages empty.
module long_press_power_sequencer_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write port
	input  logic                                 cfg_we,
	input  logic [lpps_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [lpps_pkg::CfgDataW-1:0]        cfg_data,
	// tick channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 button_pressed,
	input  logic                                 link_ready,
	input  logic                                 fade_done,
	input  logic [lpps_pkg::DtW-1:0]             elapsed_ms,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [lpps_pkg::ModeW-1:0]           mode,
	output logic                                 poll_enable,
	output logic                                 start_fade,
	output logic                                 prepare_off,
	output logic                                 power_off
);

	lpps_pkg::cfg_t       cfg;
	lpps_pkg::seq_state_t state_q;
	lpps_pkg::seq_state_t state_nxt;
	lpps_pkg::tick_t      tick_s1;
	lpps_pkg::result_t    res_nxt;
	lpps_pkg::result_t    res_s2;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 out_ready;
	logic                 advance;
	logic                 s1_ready;

	lpps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lpps_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.tick (tick_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// flow control: result reg frees when empty or taken this cycle
	assign out_ready = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign s1_ready  = !valid_s1 || out_ready;
	assign in_stall  = !s1_ready;

	// stage valids and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{mode: lpps_pkg::MODE_IDLE, was_pressed: 1'b0, hold_active: 1'b0,
				hold_elapsed: '0, rel_started: 1'b0, rel_elapsed: '0};
		end else begin
			if (s1_ready) begin
				valid_s1 <= in_valid;
			end
			if (out_ready) begin
				valid_s2 <= valid_s1;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && s1_ready) begin
			tick_s1 <= '{button_pressed: button_pressed, link_ready: link_ready,
				fade_done: fade_done, elapsed_ms: elapsed_ms};
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign mode        = res_s2.mode;
	assign poll_enable = res_s2.poll_enable;
	assign start_fade  = res_s2.start_fade;
	assign prepare_off = res_s2.prepare_off;
	assign power_off   = res_s2.power_off;

	// off is terminal
	a_off_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == lpps_pkg::MODE_OFF |=> state_q.mode == lpps_pkg::MODE_OFF)
		else $error("sequencer left off mode");

	// start_fade and power_off each match the mode they enter
	a_fade_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.start_fade |-> res_s2.mode == lpps_pkg::MODE_SHUTTING)
		else $error("start_fade without shutting mode");

	a_poff_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.power_off |-> res_s2.mode == lpps_pkg::MODE_OFF)
		else $error("power_off without off mode");

	// at most one pulse per result
	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0({res_s2.start_fade, res_s2.prepare_off, res_s2.power_off}))
		else $error("more than one sequencing pulse");

	// state only moves when a tick transfers into the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a tick");

endmodule

// ===== sim/power_sequence_checker.sv =====
`timescale 1ns / 1ps

module power_sequence_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lpps_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [lpps_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          button_pressed,
	input  logic                          link_ready,
	input  logic                          fade_done,
	input  logic [lpps_pkg::DtW-1:0]      elapsed_ms,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [lpps_pkg::ModeW-1:0]    mode,
	input  logic                          poll_enable,
	input  logic                          start_fade,
	input  logic                          prepare_off,
	input  logic                          power_off,
	output int                            mismatches,
	output int                            reports_due
);
	import lpps_pkg::*;

	cfg_t       regs;
	seq_state_t seq;
	result_t    due_reports[$];

	// hold timer: rising edge arms it, held ticks add time, release clears it
	function automatic logic hold_fires(input logic pressed, input logic [DtW-1:0] dt);
		logic [HoldW:0] sum;
		logic           fire;
		sum = {1'b0, seq.hold_elapsed} + {{(HoldW + 1 - DtW){1'b0}}, dt};
		if (pressed && !seq.was_pressed) begin
			seq.hold_active  = 1'b1;
			seq.hold_elapsed = '0;
		end else if (pressed && seq.hold_active) begin
			seq.hold_elapsed = sum[HoldW] ? '1 : sum[HoldW-1:0];
		end
		seq.was_pressed = pressed;
		fire = pressed && seq.hold_active && (seq.hold_elapsed >= regs.hold_limit_ms);
		if (!pressed) begin
			seq.hold_active  = 1'b0;
			seq.hold_elapsed = '0;
		end
		return fire;
	endfunction

	// one sample tick through the mode machine
	function automatic result_t advance_sequencer(input tick_t tk);
		result_t       r;
		logic [RelW:0] rsum;
		r = '0;
		rsum = {1'b0, seq.rel_elapsed} + {{(RelW + 1 - DtW){1'b0}}, tk.elapsed_ms};
		case (seq.mode)
			MODE_IDLE: begin
				if (hold_fires(tk.button_pressed, tk.elapsed_ms)) begin
					seq.mode     = MODE_SHUTTING;
					r.start_fade = 1'b1;
				end else if (tk.link_ready) begin
					seq.mode = MODE_RUNNING;
				end
			end
			MODE_RUNNING: begin
				if (hold_fires(tk.button_pressed, tk.elapsed_ms)) begin
					seq.mode     = MODE_SHUTTING;
					r.start_fade = 1'b1;
				end else begin
					// link drop still counts as a polling tick
					r.poll_enable = 1'b1;
					if (!tk.link_ready) begin
						seq.mode = MODE_IDLE;
					end
				end
			end
			MODE_SHUTTING: begin
				if (tk.fade_done) begin
					seq.mode        = MODE_SLEEP;
					r.prepare_off   = 1'b1;
					seq.rel_started = 1'b0;
					seq.rel_elapsed = '0;
				end
			end
			MODE_SLEEP: begin
				if (tk.button_pressed) begin
					seq.rel_started = 1'b0;
					seq.rel_elapsed = '0;
				end else if (!seq.rel_started) begin
					seq.rel_started = 1'b1;
					seq.rel_elapsed = '0;
				end else begin
					seq.rel_elapsed = rsum[RelW] ? '1 : rsum[RelW-1:0];
					if (seq.rel_elapsed >= regs.release_stable_ms) begin
						seq.mode    = MODE_OFF;
						r.power_off = 1'b1;
					end
				end
			end
			default: begin
				seq.mode = MODE_OFF;
			end
		endcase
		r.mode = seq.mode;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [ModeW-1:0] want,
			input logic [ModeW-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		tick_t   tk;
		if (!arst_n) begin
			regs.hold_limit_ms     = HoldLimitRst;
			regs.release_stable_ms = RelStableRst;
			seq                    = '0;
			seq.mode               = MODE_IDLE;
			due_reports.delete();
			mismatches             = 0;
			reports_due            = 0;
		end else begin
			// result transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				if (due_reports.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual mode %0d",
						$time, mode);
				end else begin
					want = due_reports.pop_front();
					check_field("mode", want.mode, mode);
					check_field("poll_enable", 3'(want.poll_enable), 3'(poll_enable));
					check_field("start_fade", 3'(want.start_fade), 3'(start_fade));
					check_field("prepare_off", 3'(want.prepare_off), 3'(prepare_off));
					check_field("power_off", 3'(want.power_off), 3'(power_off));
				end
			end
			// register writes; unknown indexes are dropped
			if (cfg_we) begin
				case (cfg_index)
					CfgIdxHold: regs.hold_limit_ms = cfg_data;
					CfgIdxRel:  regs.release_stable_ms = cfg_data[RelW-1:0];
					default: ;
				endcase
			end
			// tick transfer
			if (in_valid && !in_stall) begin
				tk.button_pressed = button_pressed;
				tk.link_ready     = link_ready;
				tk.fade_done      = fade_done;
				tk.elapsed_ms     = elapsed_ms;
				due_reports.push_back(advance_sequencer(tk));
			end
			reports_due = due_reports.size();
		end
	end

endmodule

// ===== sim/long_press_power_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps

module long_press_power_sequencer_unit_tb;
	import lpps_pkg::*;

	localparam int CycleLimit = 300000;
	// indexes past the last register, written to check they are dropped
	localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic                button_pressed;
	logic                link_ready;
	logic                fade_done;
	logic [DtW-1:0]      elapsed_ms;
	logic                out_valid;
	logic                out_stall;
	logic [ModeW-1:0]    mode;
	logic                poll_enable;
	logic                start_fade;
	logic                prepare_off;
	logic                power_off;
	int                  mismatches;
	int                  reports_due;

	// sender state: burst length, a shadow of the hold timer, press and link episodes
	int   burst_left;
	int   hold_limit_now;
	logic btn_was_down;
	int   btn_held_ms;
	logic btn_level;
	logic link_level;
	int   btn_run;
	int   link_run;
	bit   hold_off_req;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	long_press_power_sequencer_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.button_pressed (button_pressed),
		.link_ready     (link_ready),
		.fade_done      (fade_done),
		.elapsed_ms     (elapsed_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mode           (mode),
		.poll_enable    (poll_enable),
		.start_fade     (start_fade),
		.prepare_off    (prepare_off),
		.power_off      (power_off)
	);

	power_sequence_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.button_pressed (button_pressed),
		.link_ready     (link_ready),
		.fade_done      (fade_done),
		.elapsed_ms     (elapsed_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mode           (mode),
		.poll_enable    (poll_enable),
		.start_fade     (start_fade),
		.prepare_off    (prepare_off),
		.power_off      (power_off),
		.mismatches     (mismatches),
		.reports_due    (reports_due)
	);

	function automatic logic coin_flip();
		return 1'($urandom_range(0, 1));
	endfunction

	// hold time after a pressed tick of dt, as the block will count it
	function automatic int held_after(input logic [DtW-1:0] dt);
		int s;
		s = btn_held_ms + int'(dt);
		if (!btn_was_down) begin
			return 0;
		end
		return (s > 65535) ? 65535 : s;
	endfunction

	// one tick transfer; called and returns at a falling edge
	task automatic send_tick(input logic b, input logic l, input logic f, input logic [DtW-1:0] dt);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid       <= 1'b1;
		button_pressed <= b;
		link_ready     <= l;
		fade_done      <= f;
		elapsed_ms     <= dt;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
		btn_held_ms  = b ? held_after(dt) : 0;
		btn_was_down = b;
	endtask

	// stop sending and wait for every predicted result
	task automatic drain();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (reports_due != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == CfgIdxHold) begin
			hold_limit_now = int'(data);
		end
	endtask

	// idle/running traffic: press and link episodes of random length,
	// presses cut just short of the hold limit
	task automatic random_ticks(input int count);
		logic           b;
		logic [DtW-1:0] dt;
		repeat (count) begin
			if (btn_run == 0) begin
				btn_level = ~btn_level;
				btn_run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300)
					: $urandom_range(1, 12);
			end
			if (link_run == 0) begin
				link_level = ~link_level;
				link_run = $urandom_range(1, 40);
			end
			btn_run--;
			link_run--;
			if (btn_run > 20 && $urandom_range(0, 3) != 0) begin
				dt = '1;
			end else begin
				case ($urandom_range(0, 4))
					0: dt = '0;
					1: dt = '1;
					2: dt = 8'($urandom_range(1, 16));
					default: dt = 8'($urandom_range(0, 255));
				endcase
			end
			b = btn_level;
			if (b && held_after(dt) >= hold_limit_now) begin
				b         = 1'b0;
				btn_level = 1'b0;
				btn_run   = $urandom_range(1, 6);
			end
			send_tick(b, link_level, coin_flip(), dt);
		end
	endtask

	// result side: stall segments of varying density, plus long hold-offs on request
	initial begin : result_sink
		int   seg_left;
		int   seg_kind;
		int   hold_left;
		int   period;
		int   phase;
		logic stall_now;
		out_stall = 1'b0;
		seg_left  = 0;
		seg_kind  = 0;
		hold_left = 0;
		period    = 2;
		phase     = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = $urandom_range(60, 120);
			end
			if (hold_left > 0) begin
				stall_now = 1'b1;
				hold_left--;
			end else begin
				if (seg_left == 0) begin
					seg_kind = $urandom_range(0, 3);
					seg_left = $urandom_range(5, 60);
					period   = $urandom_range(2, 5);
				end
				seg_left--;
				phase++;
				case (seg_kind)
					0: stall_now = 1'b0;
					1: stall_now = ($urandom_range(0, 3) == 0);
					2: stall_now = ($urandom_range(0, 3) != 0);
					default: stall_now = ((phase % period) == 0);
				endcase
			end
			out_stall <= stall_now;
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [HoldW-1:0]    phase_limit [5];
		logic [CfgDataW-1:0] final_rel;
		int                  rel_run;
		logic                b;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CfgIdxHold;
		cfg_data       = '0;
		in_valid       = 1'b0;
		button_pressed = 1'b0;
		link_ready     = 1'b0;
		fade_done      = 1'b0;
		elapsed_ms     = '0;
		burst_left     = 0;
		hold_limit_now = int'(HoldLimitRst);
		btn_was_down   = 1'b0;
		btn_held_ms    = 0;
		btn_level      = 1'b0;
		link_level     = 1'b0;
		btn_run        = 0;
		link_run       = 0;
		hold_off_req   = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: link up/down, fade ignored, hold one ms short of the default limit
		send_tick(1'b0, 1'b0, 1'b1, 8'd0);
		send_tick(1'b0, 1'b1, 1'b0, 8'd255);
		send_tick(1'b0, 1'b1, 1'b1, 8'd17);
		send_tick(1'b0, 1'b0, 1'b0, 8'd0);
		send_tick(1'b0, 1'b0, 1'b0, 8'd90);
		send_tick(1'b1, 1'b0, 1'b0, 8'd255);
		repeat (11) send_tick(1'b1, 1'b0, 1'b1, 8'd255);
		send_tick(1'b1, 1'b1, 1'b0, 8'd194);
		send_tick(1'b1, 1'b1, 1'b0, 8'd0);
		send_tick(1'b0, 1'b1, 1'b0, 8'd255);
		// press edge while running, with the link dropping on the same tick
		send_tick(1'b1, 1'b0, 1'b0, 8'd100);
		send_tick(1'b0, 1'b0, 1'b1, 8'd0);
		drain();

		// idle/running traffic under several hold limits
		phase_limit[0] = '1;
		phase_limit[1] = 16'($urandom_range(1, 65535));
		phase_limit[2] = 16'd1;
		phase_limit[3] = 16'($urandom_range(2, 400));
		phase_limit[4] = 16'($urandom_range(1000, 5000));
		for (int p = 0; p < 5; p++) begin
			write_reg(CfgIdxHold, phase_limit[p]);
			write_reg(CfgIdxRel, 16'($urandom));
			write_reg((p % 2 == 0) ? CfgIdxSpareLo : CfgIdxSpareHi, 16'($urandom));
			if (p == 1 || p == 3) begin
				hold_off_req = 1'b1;
			end
			random_ticks(280);
			drain();
		end

		// shutdown by a long press, either on the edge with a zero limit or by a real hold
		if (coin_flip()) begin
			write_reg(CfgIdxHold, '0);
			send_tick(1'b0, coin_flip(), coin_flip(), 8'($urandom));
			send_tick(1'b1, coin_flip(), coin_flip(), 8'($urandom));
		end else begin
			write_reg(CfgIdxHold, 16'($urandom_range(1, 1500)));
			send_tick(1'b0, coin_flip(), coin_flip(), 8'($urandom));
			do send_tick(1'b1, coin_flip(), coin_flip(), 8'($urandom));
			while (btn_held_ms < hold_limit_now);
		end
		drain();

		// shutting down: everything but fade_done is ignored
		write_reg(CfgIdxHold, '0);
		write_reg(CfgIdxRel, '0);
		repeat (40) send_tick(coin_flip(), coin_flip(), 1'b0, 8'($urandom));
		drain();
		write_reg(CfgIdxRel, 16'hFFFF);
		send_tick(coin_flip(), coin_flip(), 1'b1, 8'($urandom));

		// deep sleep at the top threshold; releases never last long enough to power off
		rel_run = 0;
		repeat (120) begin
			b = (rel_run == 4) || ($urandom_range(0, 2) == 0);
			rel_run = b ? 0 : rel_run + 1;
			send_tick(b, coin_flip(), coin_flip(), 8'($urandom));
		end
		drain();

		// long releases until power off, then the off mode ignores everything
		case ($urandom_range(0, 2))
			0: final_rel = '0;
			1: final_rel = 16'($urandom_range(1, 1022));
			default: final_rel = 16'd1023;
		endcase
		write_reg(CfgIdxRel, final_rel);
		repeat (80) send_tick(($urandom_range(0, 15) == 0), coin_flip(), coin_flip(),
			8'($urandom));
		repeat (25) send_tick(coin_flip(), coin_flip(), coin_flip(), 8'($urandom));
		drain();
		repeat (8) @(negedge clk);

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/lpps_pkg.sv
design/lpps_cfg_regs.sv
design/lpps_step.sv
design/long_press_power_sequencer_unit.sv
sim/power_sequence_checker.sv
sim/long_press_power_sequencer_unit_tb.sv
